[sv/maze_generation_dfs_unit_defines.svh]
// Assertion macros shared by the maze generator RTL.
`ifndef MAZE_GENERATION_DFS_UNIT_DEFINES_SVH
`define MAZE_GENERATION_DFS_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define MGD_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition in one cycle that forces a consequence in the next cycle.
`define MGD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/mgdfs_pkg.sv]
// Types, codes and helper functions for the maze generator.
package mgdfs_pkg;

  localparam int MAX_SIDE_DEF  = 64;
  localparam int CELLS_MAX_DEF = 4096;

  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int COORD_OUT_W = 6;

  localparam logic [CFG_W-1:0] SIDE_RESET  = 7'd12;
  localparam logic [7:0]       ORDER_RESET = 8'd228;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_CARVE  = 2'd1;
  localparam logic [1:0] ACT_BACK   = 2'd2;
  localparam logic [1:0] ACT_FINISH = 2'd3;

  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  // Swap pairs in coin order: (0,1),(0,2),(0,3),(1,2),(1,3),(2,3).
  localparam logic [11:0] SWAP_A = {2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0};
  localparam logic [11:0] SWAP_B = {2'd3, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1};

  typedef struct packed {
    logic       opcode;
    logic [5:0] random_bits;
  } in_word_t;

  typedef struct packed {
    logic [1:0]             action;
    logic [COORD_OUT_W-1:0] from_x;
    logic [COORD_OUT_W-1:0] from_y;
    logic [COORD_OUT_W-1:0] to_x;
    logic [COORD_OUT_W-1:0] to_y;
    logic [1:0]             carve_dir;
  } out_word_t;

  // Six conditional swaps of the packed direction order, in coin order.
  function automatic logic [7:0] shuffle_order(input logic [7:0] order,
                                               input logic [5:0] coins);
    logic [7:0] o;
    logic [1:0] a;
    logic [1:0] b;
    logic [1:0] va;
    logic [1:0] vb;
    o = order;
    for (int k = 0; k < 6; k++) begin
      a  = SWAP_A[2*k +: 2];
      b  = SWAP_B[2*k +: 2];
      va = o[{a, 1'b0} +: 2];
      vb = o[{b, 1'b0} +: 2];
      if (coins[k]) begin
        o[{a, 1'b0} +: 2] = vb;
        o[{b, 1'b0} +: 2] = va;
      end
    end
    return o;
  endfunction

endpackage

[sv/maze_generation_dfs_unit.sv]
// Depth-first backtracking maze generator with visited map and return stack.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+-----------------------------------
//  in      | input     | in_valid/in_stall  | opcode, random_bits
//  out     | output    | out_valid/out_stall| action, from/to cell, carve_dir
//  cfg     | input     | cfg_valid/cfg_ready| register index, write data
//
//  A step word is shuffled at the accepting edge itself. Then come up to four
//  probes through the single read port of the visited map, each in S_PROBE
//  and, for a neighbour inside the maze, S_CHECK; a pop through the stack
//  read port in S_POP and S_POPW; and the load of the output register in
//  S_EMIT.
//  A start word sweeps the whole visited map, one cell a cycle, marking only
//  the origin, before its result is loaded.
//  After reset the sweep runs once, with the origin left unmarked, before the
//  first word is taken; configuration writes are taken throughout.
//  A stalled result stays in the output register while the next word is
//  accepted; that word waits for the register only at its final cycle.
module maze_generation_dfs_unit
  import mgdfs_pkg::*;
#(
  parameter int MAX_SIDE  = MAX_SIDE_DEF,
  parameter int CELLS_MAX = CELLS_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

`include "maze_generation_dfs_unit_defines.svh"

  // Coordinate width, the comparison width for the bounds test, and the sizes
  // of the two memories.  The visited map is addressed by {y, x}.
  localparam int CW     = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int KW     = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int VAW    = 2 * CW;
  localparam int VDEPTH = 1 << VAW;
  localparam int SAW    = $clog2(CELLS_MAX);
  localparam int SCW    = $clog2(CELLS_MAX + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;
  localparam logic [2:0] S_POPW  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  // Configuration registers.
  logic [CFG_W-1:0] maze_width;
  logic [CFG_W-1:0] maze_height;

  // Control state.
  logic [2:0]     state;
  logic [VAW-1:0] clr_addr;
  logic           clr_start;
  logic [1:0]     probe_i;
  logic [SCW-1:0] stack_count;
  logic [7:0]     dir_order;
  logic [CW-1:0]  cur_x;
  logic [CW-1:0]  cur_y;

  // Result being built and its source cell; no reset needed.
  logic [1:0]    res_action;
  logic [1:0]    res_dir;
  logic [CW-1:0] from_x;
  logic [CW-1:0] from_y;

  // Memories with registered read data.
  logic             vis_mem [VDEPTH];
  logic [2*CW-1:0]  stk_mem [CELLS_MAX];
  logic             vis_q;
  logic [2*CW-1:0]  stk_q;

  logic           in_fire;
  logic           out_free;
  logic [KW-1:0]  w_eff;
  logic [KW-1:0]  h_eff;
  logic [1:0]     probe_dir;
  logic [CW:0]    nx;
  logic [CW:0]    ny;
  logic           nb_neg;
  logic           nb_inb;
  logic [VAW-1:0] vis_raddr;
  logic           vis_we;
  logic [VAW-1:0] vis_waddr;
  logic           vis_wdata;
  logic           stk_we;
  logic [SCW-1:0] cnt_dec;
  logic           can_push;
  logic           fail_pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cnt_dec   = stack_count - SCW'(1);
  assign can_push  = (stack_count < SCW'(CELLS_MAX));
  assign fail_pop  = (stack_count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      maze_width  <= SIDE_RESET;
      maze_height <= SIDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIDTH:  maze_width  <= cfg_data;
        REG_HEIGHT: maze_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // A side of zero counts as one, and one above MAX_SIDE as MAX_SIDE.
  always_comb begin
    w_eff = KW'(maze_width);
    h_eff = KW'(maze_height);
    if (w_eff == '0) begin
      w_eff = KW'(1);
    end else if (w_eff > KW'(MAX_SIDE)) begin
      w_eff = KW'(MAX_SIDE);
    end
    if (h_eff == '0) begin
      h_eff = KW'(1);
    end else if (h_eff > KW'(MAX_SIDE)) begin
      h_eff = KW'(MAX_SIDE);
    end
  end

  // Neighbour in the probed slot of the order.  A step past the left or top
  // edge is flagged rather than wrapped; the far edges are caught by the
  // compare against the effective size, which applies to every neighbour,
  // also one of a current cell that lies outside a shrunken maze.
  always_comb begin
    probe_dir = dir_order[{probe_i, 1'b0} +: 2];
    nx        = {1'b0, cur_x};
    ny        = {1'b0, cur_y};
    nb_neg    = 1'b0;
    unique case (probe_dir)
      DIR_LEFT: begin
        nx     = {1'b0, cur_x} - (CW+1)'(1);
        nb_neg = (cur_x == '0);
      end
      DIR_RIGHT: nx = {1'b0, cur_x} + (CW+1)'(1);
      DIR_UP: begin
        ny     = {1'b0, cur_y} - (CW+1)'(1);
        nb_neg = (cur_y == '0);
      end
      DIR_DOWN: ny = {1'b0, cur_y} + (CW+1)'(1);
      default: ;
    endcase
    nb_inb    = !nb_neg && (KW'(nx) < w_eff) && (KW'(ny) < h_eff);
    vis_raddr = {ny[CW-1:0], nx[CW-1:0]};
  end

  // Visited map write port: the clearing sweep, or the mark of a carve.
  always_comb begin
    vis_we    = 1'b0;
    vis_waddr = vis_raddr;
    vis_wdata = 1'b1;
    stk_we    = 1'b0;
    if (state == S_CLEAR) begin
      vis_we    = 1'b1;
      vis_waddr = clr_addr;
      vis_wdata = clr_start && (clr_addr == '0);
    end else if (state == S_CHECK && !vis_q) begin
      vis_we = 1'b1;
      stk_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    vis_q <= vis_mem[vis_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stack_count[SAW-1:0]] <= {cur_y, cur_x};
    end
    stk_q <= stk_mem[cnt_dec[SAW-1:0]];
  end

  // Sequencer.  Every word ends in S_EMIT, which waits for the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      clr_start   <= 1'b0;
      probe_i     <= '0;
      stack_count <= '0;
      dir_order   <= ORDER_RESET;
      cur_x       <= '0;
      cur_y       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + VAW'(1);
          if (clr_addr == VAW'(VDEPTH - 1)) begin
            state <= clr_start ? S_EMIT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            from_x  <= cur_x;
            from_y  <= cur_y;
            res_dir <= DIR_LEFT;
            probe_i <= '0;
            if (in_data.opcode == OP_START) begin
              res_action  <= ACT_START;
              stack_count <= '0;
              dir_order   <= ORDER_RESET;
              cur_x       <= '0;
              cur_y       <= '0;
              clr_addr    <= '0;
              clr_start   <= 1'b1;
              state       <= S_CLEAR;
            end else begin
              dir_order <= shuffle_order(dir_order, in_data.random_bits);
              if (can_push) begin
                state <= S_PROBE;
              end else begin
                state <= S_POP;
              end
            end
          end
        end
        S_PROBE: begin
          if (nb_inb) begin
            state <= S_CHECK;
          end else if (probe_i == 2'd3) begin
            res_action <= ACT_FINISH;
            state      <= fail_pop ? S_POP : S_EMIT;
          end else begin
            probe_i <= probe_i + 2'd1;
          end
        end
        S_CHECK: begin
          if (!vis_q) begin
            stack_count <= stack_count + SCW'(1);
            cur_x       <= nx[CW-1:0];
            cur_y       <= ny[CW-1:0];
            res_action  <= ACT_CARVE;
            res_dir     <= probe_dir;
            state       <= S_EMIT;
          end else if (probe_i == 2'd3) begin
            res_action <= ACT_FINISH;
            state      <= fail_pop ? S_POP : S_EMIT;
          end else begin
            probe_i <= probe_i + 2'd1;
            state   <= S_PROBE;
          end
        end
        S_POP: begin
          stack_count <= cnt_dec;
          state       <= S_POPW;
        end
        S_POPW: begin
          cur_y      <= stk_q[2*CW-1:CW];
          cur_x      <= stk_q[CW-1:0];
          res_action <= ACT_BACK;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register; the destination is always the current cell.
  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      out_data.action    <= res_action;
      out_data.from_x    <= COORD_OUT_W'(from_x);
      out_data.from_y    <= COORD_OUT_W'(from_y);
      out_data.to_x      <= COORD_OUT_W'(cur_x);
      out_data.to_y      <= COORD_OUT_W'(cur_y);
      out_data.carve_dir <= res_dir;
    end
  end

  `MGD_ASSERT_HOLDS(a_stack_bound, stack_count <= SCW'(CELLS_MAX), "stack count above depth")
  `MGD_ASSERT_NEXT(a_carve_push, state == S_CHECK && !vis_q, stack_count == $past(stack_count) + SCW'(1), "carve did not push")
  `MGD_ASSERT_NEXT(a_emit_loads, state == S_EMIT && out_free, out_valid && state == S_IDLE, "result not loaded")
  `MGD_ASSERT_HOLDS(a_start_origin, !(out_valid && out_data.action == ACT_START) || (out_data.to_x == '0 && out_data.to_y == '0), "start word not at origin")

endmodule

[tb/sv/maze_generation_dfs_checker.sv]
// Checker for the maze generator: predicts every result word and compares it with the block.
`timescale 1ns / 1ps
module maze_generation_dfs_checker
  import mgdfs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_word_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_word_t            out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatch_count,
  output int                   moves_awaited,
  output int                   moves_carved,
  output int                   moves_finished
);

  localparam int SIDE       = MAX_SIDE_DEF;
  localparam int CELLS      = CELLS_MAX_DEF;
  localparam int REPORT_MAX = 40;

  logic [CFG_W-1:0]         maze_cols;
  logic [CFG_W-1:0]         maze_rows;
  logic                     seen [SIDE*SIDE];
  logic [2*COORD_OUT_W-1:0] trail [CELLS];
  int                       depth;
  logic [1:0]               heading [4];
  logic [COORD_OUT_W-1:0]   pos_x;
  logic [COORD_OUT_W-1:0]   pos_y;
  out_word_t                moves_due [$];
  int                       errors;
  int                       carved;
  int                       finished;

  function automatic int usable_side(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > SIDE) return SIDE;
    return int'(v);
  endfunction

  task automatic restart_walk();
    foreach (seen[i]) seen[i] = 1'b0;
    depth   = 0;
    heading = '{DIR_LEFT, DIR_RIGHT, DIR_UP, DIR_DOWN};
    pos_x   = '0;
    pos_y   = '0;
  endtask

  // One start or step of the depth-first walk; r is the word the block must return.
  task automatic advance_walk(input in_word_t w, output out_word_t r);
    int         cols;
    int         rows;
    int         nx;
    int         ny;
    int         a;
    int         b;
    logic [1:0] d;
    logic [1:0] t;
    bit         found;
    r        = '0;
    r.from_x = pos_x;
    r.from_y = pos_y;
    cols     = usable_side(maze_cols);
    rows     = usable_side(maze_rows);
    if (w.opcode == OP_START) begin
      restart_walk();
      seen[0]  = 1'b1;
      r.action = ACT_START;
    end else begin
      for (int k = 0; k < 6; k++) begin
        case (k)
          0: begin a = 0; b = 1; end
          1: begin a = 0; b = 2; end
          2: begin a = 0; b = 3; end
          3: begin a = 1; b = 2; end
          4: begin a = 1; b = 3; end
          default: begin a = 2; b = 3; end
        endcase
        if (w.random_bits[k]) begin
          t          = heading[a];
          heading[a] = heading[b];
          heading[b] = t;
        end
      end
      found = 1'b0;
      // A full stack blocks every carve, so the step falls through to a pop.
      if (depth < CELLS) begin
        for (int i = 0; i < 4; i++) begin
          if (!found) begin
            d  = heading[i];
            nx = int'(pos_x);
            ny = int'(pos_y);
            case (d)
              DIR_LEFT:  nx = nx - 1;
              DIR_RIGHT: nx = nx + 1;
              DIR_UP:    ny = ny - 1;
              DIR_DOWN:  ny = ny + 1;
            endcase
            if (nx >= 0 && ny >= 0 && nx < cols && ny < rows && !seen[ny*SIDE + nx]) begin
              trail[depth]      = {pos_y, pos_x};
              depth             = depth + 1;
              pos_x             = COORD_OUT_W'(nx);
              pos_y             = COORD_OUT_W'(ny);
              seen[ny*SIDE + nx] = 1'b1;
              r.carve_dir       = d;
              found             = 1'b1;
            end
          end
        end
      end
      if (found) begin
        r.action = ACT_CARVE;
        carved++;
      end else if (depth > 0) begin
        depth          = depth - 1;
        {pos_y, pos_x} = trail[depth];
        r.action       = ACT_BACK;
      end else begin
        r.action = ACT_FINISH;
        finished++;
      end
    end
    r.to_x = pos_x;
    r.to_y = pos_y;
  endtask

  task automatic check_field(input string label, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= REPORT_MAX)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    out_word_t want;
    if (rst) begin
      restart_walk();
      maze_cols = SIDE_RESET;
      maze_rows = SIDE_RESET;
      moves_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WIDTH:  maze_cols = cfg_data;
          REG_HEIGHT: maze_rows = cfg_data;
          default: ;
        endcase
      end
      // Results are compared before new words are predicted: no word can
      // produce its result at the edge that accepts it.
      if (out_valid && !out_stall) begin
        if (moves_due.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("%0t: result word with none expected, actual action %0d to (%0d,%0d)",
                     $time, out_data.action, out_data.to_x, out_data.to_y);
        end else begin
          want = moves_due.pop_front();
          check_field("action", 8'(want.action), 8'(out_data.action));
          check_field("from_x", 8'(want.from_x), 8'(out_data.from_x));
          check_field("from_y", 8'(want.from_y), 8'(out_data.from_y));
          check_field("to_x", 8'(want.to_x), 8'(out_data.to_x));
          check_field("to_y", 8'(want.to_y), 8'(out_data.to_y));
          check_field("carve_dir", 8'(want.carve_dir), 8'(out_data.carve_dir));
        end
      end
      if (in_valid && !in_stall) begin
        advance_walk(in_data, want);
        moves_due.push_back(want);
      end
    end
    mismatch_count <= errors;
    moves_awaited  <= moves_due.size();
    moves_carved   <= carved;
    moves_finished <= finished;
  end

endmodule

[tb/sv/tb.sv]
// Testbench top for the maze generator: stimulus, idling control and the verdict.
`timescale 1ns / 1ps
module tb;
  import mgdfs_pkg::*;

  // The run is bounded by a cycle count far above the slowest correct run:
  // the clearing sweeps after reset and after every start each cover the
  // whole visited map, every start is followed by at least one step, and each
  // step word runs through at most four probes, a pop and the result load.
  localparam int LIMIT_CYCLES = 20_000_000;
  localparam int PHASE_WORDS  = 375;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_word_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_WIDTH;
  logic [CFG_W-1:0]     cfg_data  = SIDE_RESET;

  int          mismatch_count;
  int          moves_awaited;
  int          moves_carved;
  int          moves_finished;
  int          words_sent  = 0;
  int          reg_writes  = 0;
  int          gap_pct     = 0;
  int          stall_pct   = 0;
  int unsigned cycle_count = 0;

  always #6 clk = ~clk;

  maze_generation_dfs_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  maze_generation_dfs_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .moves_awaited  (moves_awaited),
    .moves_carved   (moves_carved),
    .moves_finished (moves_finished)
  );

  // The receiver stalls at random with the probability of the current phase.
  // stall_pct is itself changed by a nonblocking assignment, so the value
  // used at any edge never depends on the order of processes.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Watchdog: a run that hangs is reported as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb failed");
      $finish;
    end
  end

  // Six random shuffle coins.
  function automatic logic [5:0] rand_coins();
    return 6'($urandom_range(0, 63));
  endfunction

  // Offers one word, after a random number of idle cycles in the sender's
  // idle phases, and returns at the edge that accepts it. Valid is left high
  // so that back-to-back words need no extra assignment.
  task automatic send_word(input logic op, input logic [5:0] coins);
    in_word_t w;
    w.opcode      = op;
    w.random_bits = coins;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Drops valid and waits until every predicted result word has been taken.
  // The checker's count is updated at the edge itself, so settle waits for a
  // further edge after the last word went in before it first reads it.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (moves_awaited != 0) @(posedge clk);
  endtask

  // One register write. Valid is lowered for a cycle afterwards so that a
  // following write never lowers and raises it in the same time step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  // Writes both size registers; now and then also an index that names no
  // register, which the block must ignore. Only called while the block is idle.
  task automatic set_size(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
    logic [CFG_IDX_W-1:0] spare;
    write_reg(REG_WIDTH, cols);
    write_reg(REG_HEIGHT, rows);
    if ($urandom_range(0, 99) < 10) begin
      spare = CFG_IDX_W'(REG_HEIGHT + 1 + $urandom_range(0, 1));
      write_reg(spare, CFG_W'($urandom_range(0, 127)));
    end
  endtask

  // A side value near or beyond the edges of the legal range: zero is used as
  // one, anything above the maximum side as the maximum.
  function automatic logic [CFG_W-1:0] edge_side();
    case ($urandom_range(0, 5))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd63;
      3:       return 7'd64;
      default: return CFG_W'($urandom_range(65, 127));
    endcase
  endfunction

  // One maze: pick a size, start, and step until the finish report has been
  // predicted, then up to two more steps past the end. Some mazes are abandoned
  // part way by the next start, and some are resized while half built, which
  // leaves visited marks and possibly the current position out of bounds.
  task automatic run_maze();
    logic [CFG_W-1:0] cols;
    logic [CFG_W-1:0] rows;
    int               pick;
    int               steps;
    int               quit_at;
    int               resize_at;
    int               done_before;
    pick    = $urandom_range(0, 99);
    quit_at = 520;
    if (pick < 78) begin
      cols = CFG_W'($urandom_range(1, 8));
      rows = CFG_W'($urandom_range(1, 8));
    end else if (pick < 88) begin
      cols = CFG_W'($urandom_range(20, 127));
      rows = CFG_W'($urandom_range(0, 2));
    end else if (pick < 97) begin
      cols = edge_side();
      rows = CFG_W'($urandom_range(0, 3));
    end else begin
      // Large mazes are only ever walked for a while and then dropped.
      cols    = CFG_W'($urandom_range(40, 127));
      rows    = CFG_W'($urandom_range(40, 127));
      quit_at = $urandom_range(60, 160);
    end
    if ($urandom_range(0, 1)) {cols, rows} = {rows, cols};
    if ($urandom_range(0, 99) < 10) quit_at = $urandom_range(1, 30);
    resize_at = ($urandom_range(0, 99) < 12) ? $urandom_range(1, 40) : -1;

    settle();
    set_size(cols, rows);
    send_word(OP_START, rand_coins());
    done_before = moves_finished;
    steps       = 0;
    // The finish count lags by one accepted word, so one step past the end
    // of generation is always sent.
    while (moves_finished == done_before && steps < quit_at) begin
      if (steps == resize_at) begin
        settle();
        set_size(CFG_W'($urandom_range(1, 9)), CFG_W'($urandom_range(1, 9)));
      end
      send_word(OP_STEP, rand_coins());
      steps++;
    end
    repeat ($urandom_range(0, 2)) send_word(OP_STEP, rand_coins());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with neither side idling.
    // Steps before any start work on the reset state, where even the
    // origin is unmarked, so the walk may later carve back into it.
    send_word(OP_STEP, 6'h00);
    send_word(OP_STEP, 6'h3F);
    send_word(OP_STEP, 6'h15);
    send_word(OP_START, 6'h3F);
    // Each coin on its own, on the reset size of twelve by twelve.
    for (int k = 0; k < 6; k++) send_word(OP_STEP, 6'b000001 << k);

    // A one-cell maze finishes at once; a second step reports the finish again.
    settle();
    set_size(7'd1, 7'd1);
    send_word(OP_START, 6'h00);
    send_word(OP_STEP, 6'h3F);
    send_word(OP_STEP, 6'h2A);

    // Zero sizes are treated as one.
    settle();
    set_size(7'd0, 7'd0);
    send_word(OP_START, 6'h15);
    send_word(OP_STEP, 6'h00);

    // Two cells in a row: carve right, backtrack, finish.
    settle();
    set_size(7'd2, 7'd1);
    send_word(OP_START, 6'h00);
    repeat (3) send_word(OP_STEP, rand_coins());

    // Over-range sizes are cut down to the maximum side, in both directions.
    settle();
    set_size(7'd127, 7'd1);
    send_word(OP_START, 6'h3F);
    repeat (2) send_word(OP_STEP, rand_coins());
    settle();
    set_size(7'd1, 7'd127);
    send_word(OP_START, 6'h00);
    send_word(OP_STEP, rand_coins());

    // Random mazes in four idling phases: none, sender idle most of the
    // time, receiver stalling most of the time, and both lightly.
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      case (phase)
        0: begin gap_pct = 0;  stall_pct <= 0;  end
        1: begin gap_pct = 82; stall_pct <= 0;  end
        2: begin gap_pct = 0;  stall_pct <= 82; end
        default: begin gap_pct = 14; stall_pct <= 14; end
      endcase
      for (int target = words_sent + PHASE_WORDS; words_sent < target; ) run_maze();
    end

    // Drain, then keep the clock running for any stray result word.
    settle();
    repeat (24) @(posedge clk);

    $display("Summary: %0d words sent over a directed part and four idling phases,",
             words_sent);
    $display("Summary: %0d register writes, %0d passages carved, %0d finish reports checked.",
             reg_writes, moves_carved, moves_finished);
    if (mismatch_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
